FILE: src/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
// No dependencies; hpt_row, the top level and the testbench use this package.
package hpt_pkg;

    // Fixed-point format of coefficients, coordinates and results (Q16.16)
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    // Four products summed need two guard bits
    localparam int SUM_W     = PROD_W + 2;
    // Lowest sum bit that must match the sign for the result to fit
    localparam int FIT_LSB   = DATA_W - 1 + FRAC_BITS;

    // Matrix geometry
    localparam int ROWS      = 4;
    localparam int COLS      = 4;
    localparam int ENTRIES   = ROWS * COLS;
    localparam int IDX_W     = 4;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [IDX_W-1:0]         t_idx;

    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

FILE: src/hpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the matrix coefficient store.
module hpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    i_clk,
    i_wr_en,
    i_wr_addr,
    i_wr_data,
    i_rd_en,
    i_rd_addr,
    o_rd_data
);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic              i_clk;
    input  logic              i_wr_en;
    input  logic [ADDR_W-1:0] i_wr_addr;
    input  logic [WIDTH-1:0]  i_wr_data;
    input  logic              i_rd_en;
    input  logic [ADDR_W-1:0] i_rd_addr;
    output logic [WIDTH-1:0]  o_rd_data;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/hpt_row.sv
// One matrix row: three registered multiplies plus the translation term,
// then exact sum, arithmetic shift and saturation into a result register.
// Depends on hpt_pkg.
module hpt_row (
    input  logic           i_clk,
    input  logic           i_en,
    input  hpt_pkg::t_data i_coef [hpt_pkg::COLS],
    input  hpt_pkg::t_data i_x,
    input  hpt_pkg::t_data i_y,
    input  hpt_pkg::t_data i_z,
    output hpt_pkg::t_data o_value,
    output logic           o_sat
);
    import hpt_pkg::*;

    t_prod r_prod [COLS];
    t_prod n_prod [COLS];
    t_sum  n_sum;
    logic [SUM_W-FIT_LSB-1:0] n_upper;
    logic  n_fits;
    t_data n_value;
    t_data r_value;
    logic  r_sat;

    // Products; the implicit w = 1.0 column is just a shift
    always_comb begin
        n_prod[0] = PROD_W'(i_coef[0]) * PROD_W'(i_x);
        n_prod[1] = PROD_W'(i_coef[1]) * PROD_W'(i_y);
        n_prod[2] = PROD_W'(i_coef[2]) * PROD_W'(i_z);
        n_prod[3] = PROD_W'(i_coef[3]) <<< FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // Exact row sum, floor shift, saturate
    always_comb begin
        n_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1])
              + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);
        n_upper = n_sum[SUM_W-1:FIT_LSB];
        n_fits  = (&n_upper) || !(|n_upper);
        if (n_fits) begin
            n_value = n_sum[FIT_LSB:FRAC_BITS];
        end else if (n_sum[SUM_W-1]) begin
            n_value = DATA_MIN;
        end else begin
            n_value = DATA_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_sat   <= !n_fits;
        end
    end

    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

FILE: src/homogeneous_point_transform_top.sv
// Top level of the homogeneous 4x4 point transform: coefficient store,
// pipeline control and the four row units. Depends on hpt_pkg, hpt_ram, hpt_row.
//
// Usage: a load item (operation 0) writes one Q16.16 coefficient at
// matrix_index, entry_index (row*4+column) and gives no result. A transform
// item (operation 1) gives one result, M*[x,y,z,1] for the selected matrix,
// rows saturated to 32 bits, overflow set if any row saturated. One item is
// accepted every cycle unless the output is stalled; a transform result is
// registered by the store read, the multiply and the sum/saturate before it
// appears. A transform may follow a load of the same matrix directly. The
// whole pipeline holds while the output is stalled. Matrix indexes wrap
// modulo MAX_MATRICES; coefficients not loaded since reset read as undefined.
module homogeneous_point_transform_top #(
    parameter int MAX_MATRICES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_operation,
    input  hpt_pkg::t_idx  i_matrix_index,
    input  hpt_pkg::t_idx  i_entry_index,
    input  hpt_pkg::t_data i_coefficient,
    input  hpt_pkg::t_data i_coord_x,
    input  hpt_pkg::t_data i_coord_y,
    input  hpt_pkg::t_data i_coord_z,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hpt_pkg::t_data o_out_x,
    output hpt_pkg::t_data o_out_y,
    output hpt_pkg::t_data o_out_z,
    output hpt_pkg::t_data o_out_w,
    output logic           o_overflow
);
    import hpt_pkg::*;

    localparam int ADDR_W = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;

    // Matrix index reduced modulo the store size (small constant table)
    function automatic logic [ADDR_W-1:0] f_reduce(input t_idx idx);
        logic [ADDR_W-1:0] res;
        res = '0;
        for (int k = 0; k < (1 << IDX_W); k++) begin
            if (idx == IDX_W'(k)) begin
                res = ADDR_W'(k % MAX_MATRICES);
            end
        end
        return res;
    endfunction

    logic              w_en;
    logic              w_accept;
    logic              w_xform;
    logic [ADDR_W-1:0] w_addr;
    t_data             w_coef [ENTRIES];
    t_data             w_row_coef [ROWS][COLS];
    t_data             w_value [ROWS];
    logic [ROWS-1:0]   w_sat;

    logic  r_s1_valid;
    logic  r_s2_valid;
    logic  r_out_valid;
    t_data r_x;
    t_data r_y;
    t_data r_z;

    // Pipeline advances unless a finished result is held by the output;
    // no item is taken while in reset
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_xform    = w_accept && (i_operation == OP_XFORM);
    assign w_addr     = f_reduce(i_matrix_index);

    // Coefficient store: one RAM per matrix entry, all read together
    for (genvar g = 0; g < ENTRIES; g++) begin : g_store
        hpt_ram #(
            .WIDTH(DATA_W),
            .DEPTH(MAX_MATRICES)
        ) u_ram (
            .i_clk    (i_clk),
            .i_wr_en  (w_accept && (i_operation == OP_LOAD) && (i_entry_index == IDX_W'(g))),
            .i_wr_addr(w_addr),
            .i_wr_data(i_coefficient),
            .i_rd_en  (w_xform),
            .i_rd_addr(w_addr),
            .o_rd_data(w_coef[g])
        );
    end

    // Point coordinates travel alongside the store read
    always_ff @(posedge i_clk) begin
        if (w_xform) begin
            r_x <= i_coord_x;
            r_y <= i_coord_y;
            r_z <= i_coord_z;
        end
    end

    // Valid pipeline; loads leave a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= w_xform;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Row units
    for (genvar r = 0; r < ROWS; r++) begin : g_row
        for (genvar c = 0; c < COLS; c++) begin : g_col
            assign w_row_coef[r][c] = w_coef[r*COLS + c];
        end

        hpt_row u_row (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_coef (w_row_coef[r]),
            .i_x    (r_x),
            .i_y    (r_y),
            .i_z    (r_z),
            .o_value(w_value[r]),
            .o_sat  (w_sat[r])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = w_value[0];
    assign o_out_y     = w_value[1];
    assign o_out_z     = w_value[2];
    assign o_out_w     = w_value[3];
    assign o_overflow  = |w_sat;

endmodule

FILE: verif/homogeneous_point_transform_top_test.sv
// Self-checking testbench for homogeneous_point_transform_top: coefficient loads and point
// transforms are driven, and each result is checked against a predicted 4x4 transform.
// Depends on hpt_pkg and the homogeneous_point_transform_top RTL.

// One expected transform result: four rows and the saturation flag
typedef struct {
    hpt_pkg::t_data rows [4];
    logic           ovf;
} t_xform_result;

// Keeps a private copy of the coefficient store and the queue of expected results
class xform_scoreboard;
    localparam int MATRICES = 16;

    hpt_pkg::t_data coef_store [MATRICES * hpt_pkg::ENTRIES];
    t_xform_result  expected_q [$];
    int             errors;

    function new();
        foreach (coef_store[i]) coef_store[i] = '0;
        errors = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // M * [x, y, z, 1]: exact products, exact sums, floor shift, saturate
    function t_xform_result transform(hpt_pkg::t_idx midx, hpt_pkg::t_data x,
                                      hpt_pkg::t_data y, hpt_pkg::t_data z);
        logic signed [hpt_pkg::SUM_W-1:0] acc;
        logic signed [hpt_pkg::SUM_W-1:0] scaled;
        hpt_pkg::t_data                   pt [4];
        t_xform_result                    res;
        int                               base;
        base  = (int'(midx) % MATRICES) * hpt_pkg::ENTRIES;
        pt[0] = x;
        pt[1] = y;
        pt[2] = z;
        pt[3] = hpt_pkg::t_data'(1 << hpt_pkg::FRAC_BITS);
        res.ovf = 1'b0;
        for (int r = 0; r < hpt_pkg::ROWS; r++) begin
            acc = '0;
            for (int c = 0; c < hpt_pkg::COLS; c++) begin
                acc = acc + coef_store[base + r * hpt_pkg::COLS + c] * pt[c];
            end
            scaled = acc >>> hpt_pkg::FRAC_BITS;
            if (scaled > hpt_pkg::DATA_MAX) begin
                res.rows[r] = hpt_pkg::DATA_MAX;
                res.ovf     = 1'b1;
            end else if (scaled < hpt_pkg::DATA_MIN) begin
                res.rows[r] = hpt_pkg::DATA_MIN;
                res.ovf     = 1'b1;
            end else begin
                res.rows[r] = scaled[hpt_pkg::DATA_W-1:0];
            end
        end
        return res;
    endfunction

    // Accepted input item: a load updates the store, a transform queues a result
    function void note_item(logic op, hpt_pkg::t_idx midx, hpt_pkg::t_idx eidx,
                            hpt_pkg::t_data coef, hpt_pkg::t_data x,
                            hpt_pkg::t_data y, hpt_pkg::t_data z);
        if (op == hpt_pkg::OP_LOAD) begin
            coef_store[(int'(midx) % MATRICES) * hpt_pkg::ENTRIES + int'(eidx)] = coef;
        end else begin
            expected_q.push_back(transform(midx, x, y, z));
        end
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_result(hpt_pkg::t_data ox, hpt_pkg::t_data oy, hpt_pkg::t_data oz,
                               hpt_pkg::t_data ow, logic ovf);
        t_xform_result  exp_res;
        hpt_pkg::t_data got [4];
        string          names [4];
        names = '{"out_x", "out_y", "out_z", "out_w"};
        got   = '{ox, oy, oz, ow};
        if (expected_q.size() == 0) begin
            $error("result with no transform pending: out_x %h", ox);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        for (int r = 0; r < hpt_pkg::ROWS; r++) begin
            if (got[r] !== exp_res.rows[r]) begin
                $error("%s: expected %h, actual %h", names[r], exp_res.rows[r], got[r]);
                errors++;
            end
        end
        if (ovf !== exp_res.ovf) begin
            $error("overflow: expected %b, actual %b", exp_res.ovf, ovf);
            errors++;
        end
    endfunction
endclass

module homogeneous_point_transform_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS   = 450;
    localparam int QUIET_ITEMS = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MATRICES    = 16;
    localparam hpt_pkg::t_data Q_ONE  = 32'sh0001_0000;
    localparam hpt_pkg::t_data Q_HALF = 32'sh0000_8000;

    logic           i_clk          = 1'b0;
    logic           i_rst_n        = 1'b0;
    logic           i_in_valid     = 1'b0;
    logic           o_in_stall;
    logic           i_operation    = hpt_pkg::OP_LOAD;
    hpt_pkg::t_idx  i_matrix_index = '0;
    hpt_pkg::t_idx  i_entry_index  = '0;
    hpt_pkg::t_data i_coefficient  = '0;
    hpt_pkg::t_data i_coord_x      = '0;
    hpt_pkg::t_data i_coord_y      = '0;
    hpt_pkg::t_data i_coord_z      = '0;
    logic           o_out_valid;
    logic           i_out_stall    = 1'b0;
    hpt_pkg::t_data o_out_x;
    hpt_pkg::t_data o_out_y;
    hpt_pkg::t_data o_out_z;
    hpt_pkg::t_data o_out_w;
    logic           o_overflow;

    xform_scoreboard sb = new();
    int              items_sent  = 0;
    int              cycle_count = 0;
    bit              quiet       = 1'b0;
    // Entries loaded so far, tracked on the stimulus side
    bit              loaded [MATRICES][hpt_pkg::ENTRIES];

    homogeneous_point_transform_top #(
        .MAX_MATRICES(MATRICES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_matrix_index (i_matrix_index),
        .i_entry_index  (i_entry_index),
        .i_coefficient  (i_coefficient),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_out_w        (o_out_w),
        .o_overflow     (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[homogeneous_point_transform_top] ERROR");
            $finish;
        end
    end

    // Handshake monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_x, o_out_y, o_out_z, o_out_w, o_overflow);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_item(i_operation, i_matrix_index, i_entry_index, i_coefficient,
                             i_coord_x, i_coord_y, i_coord_z);
            end
        end
    end

    // Output backpressure in random bursts, none in the quiet tail
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Q16.16 value: extremes, full-range noise, or small magnitudes that rarely saturate
    function automatic hpt_pkg::t_data rand_q();
        case ($urandom_range(0, 7))
            0:       return hpt_pkg::DATA_MAX;
            1:       return hpt_pkg::DATA_MIN;
            2, 3:    return hpt_pkg::t_data'($urandom());
            default: return hpt_pkg::t_data'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic bit matrix_ready(int midx);
        for (int e = 0; e < hpt_pkg::ENTRIES; e++) begin
            if (!loaded[midx][e]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Present one item, with an optional idle burst first, and wait for acceptance
    task automatic send_item(logic op, hpt_pkg::t_idx midx, hpt_pkg::t_idx eidx,
                             hpt_pkg::t_data coef, hpt_pkg::t_data x,
                             hpt_pkg::t_data y, hpt_pkg::t_data z);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_matrix_index <= midx;
        i_entry_index  <= eidx;
        i_coefficient  <= coef;
        i_coord_x      <= x;
        i_coord_y      <= y;
        i_coord_z      <= z;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        quiet = (items_sent >= NUM_ITEMS - QUIET_ITEMS);
    endtask

    // Load carries random coordinates, which the block ignores
    task automatic load_coef(int midx, int eidx, hpt_pkg::t_data coef);
        loaded[midx][eidx] = 1'b1;
        send_item(hpt_pkg::OP_LOAD, hpt_pkg::t_idx'(midx), hpt_pkg::t_idx'(eidx), coef,
                  hpt_pkg::t_data'($urandom()), hpt_pkg::t_data'($urandom()),
                  hpt_pkg::t_data'($urandom()));
    endtask

    // Transform carries a random entry index and coefficient, which are ignored
    task automatic transform_point(int midx, hpt_pkg::t_data x, hpt_pkg::t_data y,
                                   hpt_pkg::t_data z);
        send_item(hpt_pkg::OP_XFORM, hpt_pkg::t_idx'(midx), hpt_pkg::t_idx'($urandom()),
                  hpt_pkg::t_data'($urandom()), x, y, z);
    endtask

    // Directed: one matrix with extreme rows, then extreme and rounding-sensitive points
    task automatic run_directed();
        hpt_pkg::t_data m [hpt_pkg::ENTRIES];
        m = '{hpt_pkg::DATA_MAX, hpt_pkg::DATA_MAX, hpt_pkg::DATA_MAX, hpt_pkg::DATA_MAX,
              hpt_pkg::DATA_MIN, '0, '0, hpt_pkg::DATA_MIN,
              '0, Q_ONE, '0, Q_HALF,
              -32'sd1, '0, '0, Q_ONE};
        for (int e = 0; e < hpt_pkg::ENTRIES; e++) load_coef(0, e, m[e]);
        transform_point(0, '0, '0, '0);
        transform_point(0, hpt_pkg::DATA_MAX, hpt_pkg::DATA_MAX, hpt_pkg::DATA_MAX);
        transform_point(0, hpt_pkg::DATA_MIN, hpt_pkg::DATA_MIN, hpt_pkg::DATA_MIN);
        transform_point(0, Q_ONE, -Q_ONE, 32'sh0002_8000);
        transform_point(0, -32'sd1, -32'sd1, -32'sd1);
        transform_point(0, 32'sd1, 32'sd1, 32'sd1);
    endtask

    // Random: whole-matrix reloads, stray single loads, transforms on complete matrices
    task automatic run_random();
        int ready_q [$];
        int midx;
        int start;
        bit drained;
        drained = 1'b0;
        while (items_sent < NUM_ITEMS) begin
            // Hold the sender once until the pipeline has emptied; the wait before polling
            // lets the monitor log the last accepted item first
            if (!drained && items_sent >= NUM_ITEMS / 2) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            case ($urandom_range(0, 15))
                0: begin
                    midx  = $urandom_range(0, MATRICES - 1);
                    start = $urandom_range(0, hpt_pkg::ENTRIES - 1);
                    for (int k = 0; k < hpt_pkg::ENTRIES; k++) begin
                        load_coef(midx, (start + k) % hpt_pkg::ENTRIES, rand_q());
                    end
                end
                1, 2, 3, 4: begin
                    load_coef($urandom_range(0, MATRICES - 1),
                              $urandom_range(0, hpt_pkg::ENTRIES - 1), rand_q());
                end
                default: begin
                    ready_q.delete();
                    for (int i = 0; i < MATRICES; i++) begin
                        if (matrix_ready(i)) ready_q.push_back(i);
                    end
                    transform_point(ready_q[$urandom_range(0, ready_q.size() - 1)],
                                    rand_q(), rand_q(), rand_q());
                end
            endcase
        end
    endtask

    initial begin
        foreach (loaded[i, e]) loaded[i][e] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        i_in_valid <= 1'b0;
        // Drain, then wait for any stray result
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[homogeneous_point_transform_top] OK");
        end else begin
            $display("[homogeneous_point_transform_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/hpt_pkg.sv
src/hpt_ram.sv
src/hpt_row.sv
src/homogeneous_point_transform_top.sv
verif/homogeneous_point_transform_top_test.sv
